>>> src/ckfb_pkg.sv
`default_nettype none

package ckfb_pkg;

  // Field widths
  localparam int CfgW     = 11;
  localparam int PixW     = 8;
  localparam int AddrW    = 20;
  localparam int CountW   = 21;
  localparam int OutcomeW = 2;

  // APB port widths
  localparam int PaddrW = 5;
  localparam int PdataW = 32;

  // Register map, index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_ORIGIN_X      = 3'd0,
    REG_ORIGIN_Y      = 3'd1,
    REG_WINDOW_WIDTH  = 3'd2,
    REG_WINDOW_HEIGHT = 3'd3,
    REG_KEY_COLOR     = 3'd4,
    REG_MIRROR        = 3'd5,
    REG_DEST_WIDTH    = 3'd6,
    REG_DEST_HEIGHT   = 3'd7
  } reg_idx_t;

  typedef enum logic [OutcomeW-1:0] {
    OUTCOME_COPIED      = 2'd0,
    OUTCOME_TRANSPARENT = 2'd1,
    OUTCOME_CLIPPED     = 2'd2
  } outcome_t;

  typedef struct packed {
    logic signed [CfgW-1:0] origin_x;
    logic signed [CfgW-1:0] origin_y;
    logic [CfgW-1:0]        window_width;
    logic [CfgW-1:0]        window_height;
    logic [PixW-1:0]        key_color;
    logic                   mirror;
    logic [CfgW-1:0]        dest_width;
    logic [CfgW-1:0]        dest_height;
  } cfg_t;

  // Register reset values
  localparam logic signed [CfgW-1:0] RstOriginX  = 11'sd0;
  localparam logic signed [CfgW-1:0] RstOriginY  = 11'sd9;
  localparam logic [CfgW-1:0]        RstWinW     = 11'd64;
  localparam logic [CfgW-1:0]        RstWinH     = 11'd111;
  localparam logic [PixW-1:0]        RstKey      = 8'd10;
  localparam logic                   RstMirror   = 1'b0;
  localparam logic [CfgW-1:0]        RstDestW    = 11'd224;
  localparam logic [CfgW-1:0]        RstDestH    = 11'd136;

endpackage

`default_nettype wire

>>> src/ckfb_regs.sv
`default_nettype none

module ckfb_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ckfb_pkg::PaddrW-1:0] paddr,
  input  wire logic [ckfb_pkg::PdataW-1:0] pwdata,
  output logic [ckfb_pkg::PdataW-1:0]      prdata,
  output logic                            pready,
  output ckfb_pkg::cfg_t                  cfg
);
  import ckfb_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[PaddrW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x      <= RstOriginX;
      cfg.origin_y      <= RstOriginY;
      cfg.window_width  <= RstWinW;
      cfg.window_height <= RstWinH;
      cfg.key_color     <= RstKey;
      cfg.mirror        <= RstMirror;
      cfg.dest_width    <= RstDestW;
      cfg.dest_height   <= RstDestH;
    end else if (wr) begin
      case (idx)
        REG_ORIGIN_X:      cfg.origin_x      <= $signed(pwdata[CfgW-1:0]);
        REG_ORIGIN_Y:      cfg.origin_y      <= $signed(pwdata[CfgW-1:0]);
        REG_WINDOW_WIDTH:  cfg.window_width  <= pwdata[CfgW-1:0];
        REG_WINDOW_HEIGHT: cfg.window_height <= pwdata[CfgW-1:0];
        REG_KEY_COLOR:     cfg.key_color     <= pwdata[PixW-1:0];
        REG_MIRROR:        cfg.mirror        <= pwdata[0];
        REG_DEST_WIDTH:    cfg.dest_width    <= pwdata[CfgW-1:0];
        REG_DEST_HEIGHT:   cfg.dest_height   <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_ORIGIN_X:      prdata = PdataW'($unsigned(cfg.origin_x));
      REG_ORIGIN_Y:      prdata = PdataW'($unsigned(cfg.origin_y));
      REG_WINDOW_WIDTH:  prdata = PdataW'(cfg.window_width);
      REG_WINDOW_HEIGHT: prdata = PdataW'(cfg.window_height);
      REG_KEY_COLOR:     prdata = PdataW'(cfg.key_color);
      REG_MIRROR:        prdata = PdataW'(cfg.mirror);
      REG_DEST_WIDTH:    prdata = PdataW'(cfg.dest_width);
      REG_DEST_HEIGHT:   prdata = PdataW'(cfg.dest_height);
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> src/color_keyed_flip_clip_blit.sv
// Color-keyed sprite blit address engine with horizontal flip and clipping.
// Input channel (in_valid/in_ready): one source window pixel per beat in
// raster order; first_pixel set on a beat restarts position and counts.
// Output channel (out_valid/out_ready): one result beat per input beat with
// write strobe, address and data, the outcome (copied, transparent or
// clipped), the three running counts and a flag on the window's last pixel.
// The input register loads on the edge that takes the beat, and the result
// register loads when that beat advances out of it, which a receiver stall
// can hold back. Throughput: one pixel per cycle while the receiver does not
// stall. When the receiver stalls, the result register holds and the input
// register still takes one more beat; in_ready drops only when both are full.
// Configuration comes through an APB port, registers at 4*index; the user must
// see that they are written only while idle, which the block does not enforce.
// Synchronous reset clears both stages, position and counts and loads the
// register defaults.
`default_nettype none

module color_keyed_flip_clip_blit #(
  parameter int MAX_DIMENSION = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // APB
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ckfb_pkg::PaddrW-1:0]   paddr,
  input  wire logic [ckfb_pkg::PdataW-1:0]   pwdata,
  output logic [ckfb_pkg::PdataW-1:0]        prdata,
  output logic                               pready,
  // pixel in
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [ckfb_pkg::PixW-1:0]     pixel_value,
  input  wire logic                          first_pixel,
  // result out
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               write_enable,
  output logic [ckfb_pkg::AddrW-1:0]         write_address,
  output logic [ckfb_pkg::PixW-1:0]          write_data,
  output logic [ckfb_pkg::OutcomeW-1:0]      outcome,
  output logic [ckfb_pkg::CountW-1:0]        copied_total,
  output logic [ckfb_pkg::CountW-1:0]        transparent_total,
  output logic [ckfb_pkg::CountW-1:0]        clipped_total,
  output logic                               window_done
);
  import ckfb_pkg::*;

  localparam int PW = $clog2(MAX_DIMENSION);            // position width
  localparam int CW = PW + 1;                           // clamped size width
  localparam int DW = (CW > CfgW) ? CW : CfgW;          // size compare width
  localparam int SW = CW + 1;                           // mirrored column
  localparam int XW = ((SW > CfgW) ? SW : CfgW) + 1;    // destination coords

  cfg_t cfg;

  ckfb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register
  logic            s1_valid;
  logic [PixW-1:0] s1_pixel;
  logic            s1_first;
  logic            s1_adv;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_pixel <= pixel_value;
      s1_first <= first_pixel;
    end
  end

  // Blit state
  logic [PW-1:0]     column_position;
  logic [PW-1:0]     row_position;
  logic [CountW-1:0] copied_count;
  logic [CountW-1:0] transparent_count;
  logic [CountW-1:0] clipped_count;

  // Clamp window size to 1..MAX_DIMENSION
  function automatic logic [CW-1:0] clamp_dim(input logic [CfgW-1:0] v);
    logic [DW-1:0] ve;
    ve = DW'(v);
    if (ve == '0)
      clamp_dim = CW'(1);
    else if (ve > DW'(MAX_DIMENSION))
      clamp_dim = CW'(MAX_DIMENSION);
    else
      clamp_dim = CW'(ve);
  endfunction

  function automatic logic [CountW-1:0] bump(input logic [CountW-1:0] c);
    bump = (&c) ? c : c + CountW'(1);
  endfunction

  logic [CW-1:0]        ew, eh;
  logic [PW-1:0]        col_eff, row_eff;
  logic signed [SW-1:0] mcol;
  logic signed [XW-1:0] dx, dy;
  logic                 clip, key_hit;
  logic [2*CfgW-1:0]    addr_full;
  logic                 last_col, last_row;
  logic [PW-1:0]        column_position_next, row_position_next;
  logic [CountW-1:0]    copied_count_next, transparent_count_next, clipped_count_next;
  outcome_t             outcome_next;

  always_comb begin
    ew = clamp_dim(cfg.window_width);
    eh = clamp_dim(cfg.window_height);

    // A first pixel starts from the top left
    col_eff = s1_first ? '0 : column_position;
    row_eff = s1_first ? '0 : row_position;

    // Destination coordinates, flipped when mirroring
    if (cfg.mirror)
      mcol = $signed({1'b0, ew}) - $signed(SW'(1)) - $signed({2'b00, col_eff});
    else
      mcol = $signed({2'b00, col_eff});
    dx = XW'(cfg.origin_x) + XW'(mcol);
    dy = XW'(cfg.origin_y) + $signed(XW'({1'b0, row_eff}));

    clip = dx[XW-1] || dy[XW-1]
        || ($unsigned(dx) >= XW'(cfg.dest_width))
        || ($unsigned(dy) >= XW'(cfg.dest_height));
    key_hit = (s1_pixel == cfg.key_color);

    addr_full = dy[CfgW-1:0] * cfg.dest_width + (2*CfgW)'(dx[CfgW-1:0]);

    // Counts restart on a first pixel, then bump the one that applies
    copied_count_next      = s1_first ? '0 : copied_count;
    transparent_count_next = s1_first ? '0 : transparent_count;
    clipped_count_next     = s1_first ? '0 : clipped_count;
    if (clip) begin
      outcome_next       = OUTCOME_CLIPPED;
      clipped_count_next = bump(clipped_count_next);
    end else if (key_hit) begin
      outcome_next           = OUTCOME_TRANSPARENT;
      transparent_count_next = bump(transparent_count_next);
    end else begin
      outcome_next      = OUTCOME_COPIED;
      copied_count_next = bump(copied_count_next);
    end

    // Advance raster position, wrap after the last pixel
    last_col = (CW'(col_eff) + CW'(1)) >= ew;
    last_row = (CW'(row_eff) + CW'(1)) >= eh;
    if (last_col) begin
      column_position_next = '0;
      row_position_next    = last_row ? '0 : row_eff + PW'(1);
    end else begin
      column_position_next = col_eff + PW'(1);
      row_position_next    = row_eff;
    end
  end

  // Update state as each beat moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      column_position   <= '0;
      row_position      <= '0;
      copied_count      <= '0;
      transparent_count <= '0;
      clipped_count     <= '0;
    end else if (s1_adv) begin
      column_position   <= column_position_next;
      row_position      <= row_position_next;
      copied_count      <= copied_count_next;
      transparent_count <= transparent_count_next;
      clipped_count     <= clipped_count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      write_enable      <= (outcome_next == OUTCOME_COPIED);
      write_address     <= (outcome_next == OUTCOME_COPIED) ? addr_full[AddrW-1:0] : '0;
      write_data        <= (outcome_next == OUTCOME_COPIED) ? s1_pixel : '0;
      outcome           <= outcome_next;
      copied_total      <= copied_count_next;
      transparent_total <= transparent_count_next;
      clipped_total     <= clipped_count_next;
      window_done       <= last_col && last_row;
    end
  end

  // Checks
  a_we_copied: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_enable |-> outcome == OUTCOME_COPIED)
    else $error("write strobe without copied outcome");

  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |-> write_address == '0 && write_data == '0)
    else $error("address or data set on a pixel not written");

  a_first_counts: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_first |=>
      ((CountW+2)'(copied_total) + (CountW+2)'(transparent_total)
       + (CountW+2)'(clipped_total)) == (CountW+2)'(1))
    else $error("counts not restarted on first pixel");

  a_done_wraps: assert property (@(posedge clk) disable iff (rst)
    s1_adv && last_col && last_row |=> column_position == '0 && row_position == '0)
    else $error("position not wrapped after last pixel");

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("advanced beat missing from result register");

endmodule

`default_nettype wire

>>> dv/blit_outcome_checker.sv
`timescale 1ns / 100ps

module blit_outcome_checker
  import ckfb_pkg::*;
#(
  parameter int MAX_DIMENSION = 1024
) (
  input  logic                clk,
  input  logic                rst,
  // register port, snooped for writes
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [PaddrW-1:0]   paddr,
  input  logic [PdataW-1:0]   pwdata,
  // pixel beats
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [PixW-1:0]     pixel_value,
  input  logic                first_pixel,
  // result beats
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic                write_enable,
  input  logic [AddrW-1:0]    write_address,
  input  logic [PixW-1:0]     write_data,
  input  logic [OutcomeW-1:0] outcome,
  input  logic [CountW-1:0]   copied_total,
  input  logic [CountW-1:0]   transparent_total,
  input  logic [CountW-1:0]   clipped_total,
  input  logic                window_done,
  // status for the testbench top
  output int                  fail_count,
  output int                  pending,
  output int                  copied_seen,
  output int                  transparent_seen,
  output int                  clipped_seen,
  output int                  windows_seen
);

  typedef struct packed {
    logic              we;
    logic [AddrW-1:0]  addr;
    logic [PixW-1:0]   data;
    outcome_t          kind;
    logic [CountW-1:0] copied;
    logic [CountW-1:0] transparent;
    logic [CountW-1:0] clipped;
    logic              done;
  } blit_result_t;

  // Shadow of the register file and of the walk through the window
  cfg_t              shadow_cfg;
  logic [9:0]        col_pos;
  logic [9:0]        row_pos;
  logic [CountW-1:0] copied_cnt;
  logic [CountW-1:0] transparent_cnt;
  logic [CountW-1:0] clipped_cnt;
  blit_result_t      pending_results[$];
  int                beat_index;

  // Zero acts as one, oversize acts as the largest dimension
  function automatic int effective_dim(input logic [CfgW-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_DIMENSION) return MAX_DIMENSION;
    return int'(v);
  endfunction

  function automatic logic [CountW-1:0] saturating_inc(input logic [CountW-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // Classify one pixel, then step column and row
  function automatic blit_result_t blit_pixel(input logic [PixW-1:0] pix, input logic first);
    blit_result_t r;
    int ew;
    int eh;
    int mcol;
    int dx;
    int dy;
    logic last_col;
    logic last_row;
    if (first) begin
      col_pos         = '0;
      row_pos         = '0;
      copied_cnt      = '0;
      transparent_cnt = '0;
      clipped_cnt     = '0;
    end
    ew = effective_dim(shadow_cfg.window_width);
    eh = effective_dim(shadow_cfg.window_height);
    mcol = shadow_cfg.mirror ? ew - 1 - int'(col_pos) : int'(col_pos);
    dx = int'($signed(shadow_cfg.origin_x)) + mcol;
    dy = int'($signed(shadow_cfg.origin_y)) + int'(row_pos);
    r = '0;
    if (dx < 0 || dx >= int'(shadow_cfg.dest_width) ||
        dy < 0 || dy >= int'(shadow_cfg.dest_height)) begin
      r.kind = OUTCOME_CLIPPED;
      clipped_cnt = saturating_inc(clipped_cnt);
    end else if (pix == shadow_cfg.key_color) begin
      r.kind = OUTCOME_TRANSPARENT;
      transparent_cnt = saturating_inc(transparent_cnt);
    end else begin
      r.kind = OUTCOME_COPIED;
      r.we   = 1'b1;
      r.data = pix;
      // address wraps at the width of the write bus
      r.addr = AddrW'(dy * int'(shadow_cfg.dest_width) + dx);
      copied_cnt = saturating_inc(copied_cnt);
    end
    last_col = (int'(col_pos) + 1) >= ew;
    last_row = (int'(row_pos) + 1) >= eh;
    if (last_col) begin
      col_pos = '0;
      row_pos = last_row ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    r.copied      = copied_cnt;
    r.transparent = transparent_cnt;
    r.clipped     = clipped_cnt;
    r.done        = last_col && last_row;
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] blit check: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    blit_result_t exp_r;
    if (rst) begin
      shadow_cfg = '{RstOriginX, RstOriginY, RstWinW, RstWinH,
                     RstKey, RstMirror, RstDestW, RstDestH};
      col_pos         = '0;
      row_pos         = '0;
      copied_cnt      = '0;
      transparent_cnt = '0;
      clipped_cnt     = '0;
      pending_results.delete();
      beat_index = 0;
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_ORIGIN_X:      shadow_cfg.origin_x      = pwdata[CfgW-1:0];
          REG_ORIGIN_Y:      shadow_cfg.origin_y      = pwdata[CfgW-1:0];
          REG_WINDOW_WIDTH:  shadow_cfg.window_width  = pwdata[CfgW-1:0];
          REG_WINDOW_HEIGHT: shadow_cfg.window_height = pwdata[CfgW-1:0];
          REG_KEY_COLOR:     shadow_cfg.key_color     = pwdata[PixW-1:0];
          REG_MIRROR:        shadow_cfg.mirror        = pwdata[0];
          REG_DEST_WIDTH:    shadow_cfg.dest_width    = pwdata[CfgW-1:0];
          REG_DEST_HEIGHT:   shadow_cfg.dest_height   = pwdata[CfgW-1:0];
          default: ;
        endcase
      end

      // Compare the result beat against the oldest prediction
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("result beat %0d arrived with nothing predicted", beat_index));
        end else begin
          exp_r = pending_results.pop_front();
          if (write_enable !== exp_r.we)
            flag_mismatch($sformatf("beat %0d write_enable %0b, expected %0b",
                                    beat_index, write_enable, exp_r.we));
          if (write_address !== exp_r.addr)
            flag_mismatch($sformatf("beat %0d write_address 0x%05h, expected 0x%05h",
                                    beat_index, write_address, exp_r.addr));
          if (write_data !== exp_r.data)
            flag_mismatch($sformatf("beat %0d write_data 0x%02h, expected 0x%02h",
                                    beat_index, write_data, exp_r.data));
          if (outcome !== exp_r.kind)
            flag_mismatch($sformatf("beat %0d outcome %0d, expected %s",
                                    beat_index, outcome, exp_r.kind.name()));
          if (copied_total !== exp_r.copied)
            flag_mismatch($sformatf("beat %0d copied_total %0d, expected %0d",
                                    beat_index, copied_total, exp_r.copied));
          if (transparent_total !== exp_r.transparent)
            flag_mismatch($sformatf("beat %0d transparent_total %0d, expected %0d",
                                    beat_index, transparent_total, exp_r.transparent));
          if (clipped_total !== exp_r.clipped)
            flag_mismatch($sformatf("beat %0d clipped_total %0d, expected %0d",
                                    beat_index, clipped_total, exp_r.clipped));
          if (window_done !== exp_r.done)
            flag_mismatch($sformatf("beat %0d window_done %0b, expected %0b",
                                    beat_index, window_done, exp_r.done));
          case (exp_r.kind)
            OUTCOME_COPIED:      copied_seen++;
            OUTCOME_TRANSPARENT: transparent_seen++;
            default:             clipped_seen++;
          endcase
          if (exp_r.done) windows_seen++;
        end
        beat_index++;
      end

      // Predict each accepted pixel beat
      if (in_valid && in_ready)
        pending_results.push_back(blit_pixel(pixel_value, first_pixel));
    end
    pending = pending_results.size();
  end

endmodule

>>> dv/color_keyed_flip_clip_blit_tb.sv
`timescale 1ns / 100ps

module color_keyed_flip_clip_blit_tb;
  import ckfb_pkg::*;

  localparam int QuietLimit  = 1000;
  localparam int RandomBeats = 1350;
  localparam int CalmBeats   = 150;

  logic                clk = 1'b0;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PaddrW-1:0]   paddr;
  logic [PdataW-1:0]   pwdata;
  logic [PdataW-1:0]   prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  logic [PixW-1:0]     pixel_value;
  logic                first_pixel;
  logic                out_valid;
  logic                out_ready;
  logic                write_enable;
  logic [AddrW-1:0]    write_address;
  logic [PixW-1:0]     write_data;
  logic [OutcomeW-1:0] outcome;
  logic [CountW-1:0]   copied_total;
  logic [CountW-1:0]   transparent_total;
  logic [CountW-1:0]   clipped_total;
  logic                window_done;

  int fail_count;
  int pending;
  int copied_seen;
  int transparent_seen;
  int clipped_seen;
  int windows_seen;

  int   send_gap_pct = 20;
  int   stall_pct    = 20;
  int   beats_sent   = 0;
  int   cfg_writes   = 0;
  int   quiet_cycles = 0;
  cfg_t cur_cfg;

  color_keyed_flip_clip_blit #(.MAX_DIMENSION(1024)) u_top (.*);

  blit_outcome_checker #(.MAX_DIMENSION(1024)) u_checker (.*);

  always #10 clk = ~clk;

  // Stop the run if no beat moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("[%0t] no beat moved for %0d cycles, %0d results outstanding",
               $time, QuietLimit, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: stall in random bursts
  initial begin : receiver
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  task automatic apb_write(input reg_idx_t idx, input logic [PdataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Drain all results, then load every register
  task automatic apply_cfg(input cfg_t c);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    apb_write(REG_ORIGIN_X,      {21'b0, c.origin_x});
    apb_write(REG_ORIGIN_Y,      {21'b0, c.origin_y});
    apb_write(REG_WINDOW_WIDTH,  {21'b0, c.window_width});
    apb_write(REG_WINDOW_HEIGHT, {21'b0, c.window_height});
    apb_write(REG_KEY_COLOR,     {24'b0, c.key_color});
    apb_write(REG_MIRROR,        {31'b0, c.mirror});
    apb_write(REG_DEST_WIDTH,    {21'b0, c.dest_width});
    apb_write(REG_DEST_HEIGHT,   {21'b0, c.dest_height});
    cur_cfg = c;
    cfg_writes++;
  endtask

  // Offer one pixel beat and hold it until taken
  task automatic push_pixel(input logic [PixW-1:0] pix, input logic first);
    if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    pixel_value <= pix;
    first_pixel <= first;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    beats_sent++;
  endtask

  function automatic cfg_t make_cfg(input int ox, input int oy, input int w, input int h,
                                    input int key, input int mir, input int dw, input int dh);
    cfg_t c;
    c.origin_x      = CfgW'(ox);
    c.origin_y      = CfgW'(oy);
    c.window_width  = CfgW'(w);
    c.window_height = CfgW'(h);
    c.key_color     = PixW'(key);
    c.mirror        = mir[0];
    c.dest_width    = CfgW'(dw);
    c.dest_height   = CfgW'(dh);
    return c;
  endfunction

  // Mostly small windows, now and then the out-of-range and largest sizes
  function automatic logic [CfgW-1:0] pick_window_dim();
    case ($urandom_range(0, 15))
      0:       return CfgW'(0);
      1:       return CfgW'(1024);
      2:       return CfgW'(2047);
      3:       return CfgW'($urandom_range(1, 1024));
      default: return CfgW'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [CfgW-1:0] pick_dest_dim();
    case ($urandom_range(0, 11))
      0:       return CfgW'(0);
      1:       return CfgW'(1024);
      2:       return CfgW'(2047);
      default: return CfgW'($urandom_range(1, 24));
    endcase
  endfunction

  function automatic logic [CfgW-1:0] pick_origin();
    case ($urandom_range(0, 11))
      0:       return CfgW'(-1024);
      1:       return CfgW'(1023);
      2:       return CfgW'($urandom);
      default: return CfgW'($urandom_range(0, 24) - 8);
    endcase
  endfunction

  function automatic cfg_t random_blit_cfg();
    cfg_t c;
    c.origin_x      = pick_origin();
    c.origin_y      = pick_origin();
    c.window_width  = pick_window_dim();
    c.window_height = pick_window_dim();
    case ($urandom_range(0, 5))
      0:       c.key_color = 8'h00;
      1:       c.key_color = 8'hff;
      default: c.key_color = PixW'($urandom);
    endcase
    c.mirror      = 1'($urandom_range(0, 1));
    c.dest_width  = pick_dest_dim();
    c.dest_height = pick_dest_dim();
    return c;
  endfunction

  // Bias pixels toward the key color and the extremes
  function automatic logic [PixW-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0, 1:    return cur_cfg.key_color;
      2:       return 8'h00;
      3:       return 8'hff;
      default: return PixW'($urandom);
    endcase
  endfunction

  // One blit: restart at the top if asked, with an occasional stray restart inside
  task automatic run_blit_beats(input int n, input bit restart);
    logic first;
    for (int i = 0; i < n; i++) begin
      first = (i == 0 && restart) || ($urandom_range(0, 39) == 0);
      push_pixel(pick_pixel(), first);
    end
  endtask

  initial begin : stimulus
    int  directed_beats;
    bit  calm;
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    pixel_value = '0;
    first_pixel = 1'b0;
    cur_cfg = '{RstOriginX, RstOriginY, RstWinW, RstWinH,
                RstKey, RstMirror, RstDestW, RstDestH};
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Register defaults: copy, key color, copy
    push_pixel(8'h00, 1'b1);
    push_pixel(RstKey, 1'b0);
    push_pixel(8'hff, 1'b0);

    // Tiny mirrored window hanging off a 2x1 surface, then wrap to the top
    apply_cfg(make_cfg(-1, 0, 3, 2, 255, 1, 2, 1));
    push_pixel(8'h00, 1'b1);
    push_pixel(8'hff, 1'b0);
    push_pixel(8'h01, 1'b0);
    push_pixel(8'h80, 1'b0);
    push_pixel(8'hc8, 1'b0);
    push_pixel(8'hff, 1'b0);
    push_pixel(8'h07, 1'b0);
    push_pixel(8'h55, 1'b0);

    // Zero-sized window and empty surface, origins at their extremes
    apply_cfg(make_cfg(-1024, 1023, 0, 0, 0, 0, 0, 5));
    push_pixel(8'h00, 1'b1);
    push_pixel(8'h80, 1'b0);
    push_pixel(8'haa, 1'b0);

    // Oversize window on a large surface: the write address wraps
    apply_cfg(make_cfg(1023, 1000, 2047, 1, 'h80, 0, 1500, 2047));
    push_pixel(8'h11, 1'b1);
    push_pixel(8'h80, 1'b0);
    push_pixel(8'hfe, 1'b0);
    push_pixel(8'h01, 1'b0);

    // Shrink the window mid-blit: mirrored column goes negative and clips
    apply_cfg(make_cfg(0, 0, 1, 1, 'h22, 1, 8, 8));
    push_pixel(8'h22, 1'b0);
    push_pixel(8'h33, 1'b0);
    directed_beats = beats_sent;

    // Random blits; quiet down both sides near the end
    while (beats_sent < directed_beats + RandomBeats) begin
      calm = beats_sent >= directed_beats + RandomBeats - CalmBeats;
      apply_cfg(random_blit_cfg());
      if (calm) begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       send_gap_pct = 0;
          1:       send_gap_pct = 10;
          default: send_gap_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 10;
          default: stall_pct = 40;
        endcase
      end
      run_blit_beats($urandom_range(10, 60), $urandom_range(0, 9) < 7);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("Covered %0d pixel beats over %0d register settings: %0d copied, %0d transparent,",
             beats_sent, cfg_writes + 1, copied_seen, transparent_seen);
    $display("%0d clipped, %0d complete windows.", clipped_seen, windows_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> color_keyed_flip_clip_blit.f
src/ckfb_pkg.sv
src/ckfb_regs.sv
src/color_keyed_flip_clip_blit.sv
dv/blit_outcome_checker.sv
dv/color_keyed_flip_clip_blit_tb.sv
